[rtl/core/acbf_pkg.sv]
// Shared types and character constants for the ASCII command to binary frame converter.
`timescale 1ns / 1ps
`default_nettype none

package acbf_pkg;

   localparam logic [7:0] CH_START   = 8'h2A;
   localparam logic [7:0] CH_SEP     = 8'h2C;
   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam int         FRAME_LEN  = 6;
   localparam int         FRAME_BITS = FRAME_LEN * 8;
   localparam int         COUNT_W    = $clog2(FRAME_LEN + 1);

   typedef enum logic [8:0] {
      PH_WAIT  = 9'b000000001,
      PH_SEP1  = 9'b000000010,
      PH_CMD   = 9'b000000100,
      PH_SEP2  = 9'b000001000,
      PH_A_PRE = 9'b000010000,
      PH_A_DIG = 9'b000100000,
      PH_B_PRE = 9'b001000000,
      PH_B_DIG = 9'b010000000,
      PH_DROP  = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] sum;
      logic [7:0] b_lo;
      logic [7:0] b_hi;
      logic [7:0] a_lo;
      logic [7:0] cmd;
   } frame_type;

endpackage

`default_nettype wire

[rtl/core/acbf_parser.sv]
// Line parser that tracks the command line and builds the frame contents on its newline.
`timescale 1ns / 1ps
`default_nettype none

module acbf_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [7:0]          rx_byte,
   output acbf_pkg::frame_type      frame
);
   import acbf_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] first_ff, first_in;
   logic [15:0] second_ff, second_in;
   logic        neg_ff, neg_in;
   logic        closed_ff, closed_in;

   logic        is_blank;
   logic        is_digit;
   logic [15:0] digit_val;
   logic [15:0] times_ten;
   logic [15:0] field_val;

   assign is_blank  = (rx_byte inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D});
   assign is_digit  = (rx_byte inside {[8'h30:8'h39]});
   assign digit_val = {8'h00, rx_byte - CH_ZERO};
   assign times_ten = {second_ff[12:0], 3'b000} + {second_ff[14:0], 1'b0};
   assign field_val = neg_ff ? (16'h0000 - second_ff) : second_ff;

   always_comb begin
      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      first_in  = first_ff;
      second_in = second_ff;
      neg_in    = neg_ff;
      closed_in = closed_ff;
      frame     = '0;
      frame.cmd  = cmd_ff;
      frame.a_lo = first_ff[7:0];
      frame.b_hi = field_val[15:8];
      frame.b_lo = field_val[7:0];
      frame.sum  = cmd_ff + first_ff[7:0] + field_val[15:8] + field_val[7:0];
      if (accept) begin
         if (rx_byte == CH_NL) begin
            if (phase_ff == PH_B_PRE || phase_ff == PH_B_DIG) begin
               frame.valid = 1'b1;
               second_in   = field_val;
            end
            phase_in = PH_WAIT;
         end else begin
            case (phase_ff)
               PH_WAIT: begin
                  phase_in = (rx_byte == CH_START) ? PH_SEP1 : PH_DROP;
               end
               PH_SEP1: begin
                  phase_in = (rx_byte == CH_SEP) ? PH_CMD : PH_DROP;
               end
               PH_CMD: begin
                  cmd_in   = rx_byte;
                  phase_in = PH_SEP2;
               end
               PH_SEP2: begin
                  if (rx_byte == CH_SEP) begin
                     second_in = '0;
                     neg_in    = 1'b0;
                     closed_in = 1'b0;
                     phase_in  = PH_A_PRE;
                  end else begin
                     phase_in = PH_DROP;
                  end
               end
               PH_A_PRE, PH_B_PRE: begin
                  if (phase_ff == PH_A_PRE && rx_byte == CH_SEP) begin
                     first_in  = field_val;
                     second_in = '0;
                     neg_in    = 1'b0;
                     closed_in = 1'b0;
                     phase_in  = PH_B_PRE;
                  end else if (!is_blank) begin
                     phase_in = (phase_ff == PH_A_PRE) ? PH_A_DIG : PH_B_DIG;
                     if (rx_byte == CH_MINUS) begin
                        neg_in = 1'b1;
                     end else if (is_digit) begin
                        second_in = digit_val;
                     end else if (rx_byte != CH_PLUS) begin
                        closed_in = 1'b1;
                     end
                  end
               end
               PH_A_DIG, PH_B_DIG: begin
                  if (phase_ff == PH_A_DIG && rx_byte == CH_SEP) begin
                     first_in  = field_val;
                     second_in = '0;
                     neg_in    = 1'b0;
                     closed_in = 1'b0;
                     phase_in  = PH_B_PRE;
                  end else if (!closed_ff) begin
                     if (is_digit) begin
                        second_in = times_ten + digit_val;
                     end else begin
                        closed_in = 1'b1;
                     end
                  end
               end
               default: begin
                  phase_in = PH_DROP;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         cmd_ff    <= '0;
         first_ff  <= '0;
         second_ff <= '0;
         neg_ff    <= 1'b0;
         closed_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         cmd_ff    <= cmd_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         neg_ff    <= neg_in;
         closed_ff <= closed_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/ascii_command_to_binary_frame.sv]
// Top level of the ASCII command line to binary frame converter.
`timescale 1ns / 1ps
`default_nettype none

// Text characters enter one word per cycle on the req_ side. A well-formed line
// "*,C,A,B" ending in a newline yields a six-word frame on the rsp_ side: '*', C,
// the low byte of A, the high and low bytes of B, and a checksum, with tlast on
// the checksum word. The frame sits in a shift register that sends one word per
// cycle while the receiver is ready, and the parser keeps taking characters;
// only a newline that arrives while a frame is still being sent waits, until
// the last word of that frame is taken. With a ready receiver only a line
// shorter than six characters that follows a frame stalls, and only on its
// newline.
module ascii_command_to_binary_frame (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] tx_byte
   output logic            rsp_tlast
);
   import acbf_pkg::*;

   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic [COUNT_W-1:0]    count_ff, count_in;

   frame_type frame;
   logic      busy;
   logic      last_taken;
   logic      accept;

   assign busy       = (count_ff != '0);
   assign last_taken = rsp_tready && (count_ff == COUNT_W'(1));
   assign req_tready = !busy || last_taken || (req_tdata != CH_NL);
   assign accept     = req_tvalid && req_tready;

   acbf_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_tdata),
      .frame   (frame)
   );

   assign rsp_tvalid = busy;
   assign rsp_tdata  = shift_ff[7:0];
   assign rsp_tlast  = (count_ff == COUNT_W'(1));

   always_comb begin
      shift_in = shift_ff;
      count_in = count_ff;
      if (busy && rsp_tready) begin
         shift_in = {8'h00, shift_ff[FRAME_BITS-1:8]};
         count_in = count_ff - COUNT_W'(1);
      end
      if (frame.valid) begin
         shift_in = {frame.sum, frame.b_lo, frame.b_hi, frame.a_lo, frame.cmd, CH_START};
         count_in = COUNT_W'(FRAME_LEN);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      shift_ff <= shift_in;
   end

endmodule

`default_nettype wire
